// ===== src/wshr_pkg.sv =====
// Package for the windowed sample history ring.
// Holds shared constants, the operation codes and the controller/datapath structs.
// Depends on nothing.
package wshr_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int LANES_DEF         = 4;
    localparam int MAX_LANES         = 4;
    localparam int DATA_W            = 32;
    localparam int TIME_W            = 32;
    localparam int LEN_W             = 4;
    localparam int SEL_W             = 4;
    localparam int CNT_W             = 7;
    localparam int STORED_LEN_W      = 3;
    localparam logic [CNT_W-1:0] MAX_RESULTS = CNT_W'(64);

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rec;      // write a sample into the ring
        logic clr;      // empty the ring
        logic q_start;  // latch query parameters
        logic issue;    // read the next ring entry
        logic eval;     // evaluate the entry read by the last issue
        logic finish;   // load the closing result of a query
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic can_issue;
        logic hit;
        logic hold_valid;
        logic out_free;
    } t_sts;

endpackage

// ===== src/wshr_if.sv =====
// Channel interfaces of the windowed sample history ring.
// Depends on wshr_pkg for field widths.
interface wshr_in_if import wshr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [TIME_W-1:0] sample_time;
    logic [LEN_W-1:0]  sample_len;
    logic [DATA_W-1:0] lane_a;
    logic [DATA_W-1:0] lane_b;
    logic [DATA_W-1:0] lane_c;
    logic [DATA_W-1:0] lane_d;
    logic [SEL_W-1:0]  metric_sel;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] window_len;
    logic [CNT_W-1:0]  max_out;

    modport source (
        output valid, op, sample_time, sample_len, lane_a, lane_b, lane_c, lane_d,
               metric_sel, now_time, window_len, max_out,
        input  ready
    );
    modport sink (
        input  valid, op, sample_time, sample_len, lane_a, lane_b, lane_c, lane_d,
               metric_sel, now_time, window_len, max_out,
        output ready
    );
endinterface

interface wshr_out_if import wshr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] metric_value;
    logic              valid_res;
    logic              last;
    logic [CNT_W-1:0]  copied_so_far;

    modport source (
        output valid, metric_value, valid_res, last, copied_so_far,
        input  ready
    );
    modport sink (
        input  valid, metric_value, valid_res, last, copied_so_far,
        output ready
    );
endinterface

// ===== src/windowed_sample_history_ring.sv =====
// Top level of the windowed sample history ring.
// Depends on wshr_pkg, wshr_if, wshr_ctrl and wshr_dp.
//
//  channel  | interface          | direction | transaction
//  i_in     | wshr_in_if.sink    | in        | one operation: record, query or clear
//  o_out    | wshr_out_if.source | out       | one queried value, or one empty marker
//
// A record or a clear leaves the controller idle, ready for the next operation. A query
// reads one ring entry per cycle, unless a stalled output holds the walk, from a single
// memory read port; each entry is registered and then judged, and a closing step loads
// the closing result. The walk stops at the fill count, or earlier at the limit.
// Reset empties the ring at once, with no clearing pass. A stalled output holds the walk
// only when a new match or the closing result needs the output register; no new
// operation is taken until a query has finished.
module windowed_sample_history_ring import wshr_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int LANES         = LANES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wshr_in_if.sink      i_in,
    wshr_out_if.source   o_out
);

    t_cmd cmd;
    t_sts sts;

    wshr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wshr_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .LANES         (LANES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sample_time   (i_in.sample_time),
        .i_sample_len    (i_in.sample_len),
        .i_lane_a        (i_in.lane_a),
        .i_lane_b        (i_in.lane_b),
        .i_lane_c        (i_in.lane_c),
        .i_lane_d        (i_in.lane_d),
        .i_metric_sel    (i_in.metric_sel),
        .i_now_time      (i_in.now_time),
        .i_window_len    (i_in.window_len),
        .i_max_out       (i_in.max_out),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_metric_value  (o_out.metric_value),
        .o_valid_res     (o_out.valid_res),
        .o_last          (o_out.last),
        .o_copied_so_far (o_out.copied_so_far)
    );

endmodule

// ===== src/wshr_ctrl.sv =====
// Controller of the windowed sample history ring: input handshake and query walk sequencing.
// Depends on wshr_pkg for the op codes and the command/status structs.
module wshr_ctrl import wshr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    output logic       o_in_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   accept;
    logic   stall;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // A match must push the held result out before it can take its place.
    assign stall = r_pend && i_sts.hit && i_sts.hold_valid && !i_sts.out_free;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.rec     = (i_op == OP_RECORD);
                    o_cmd.clr     = (i_op == OP_CLEAR);
                    o_cmd.q_start = (i_op == OP_QUERY);
                    if (i_op == OP_QUERY) begin
                        n_state = ST_WALK;
                    end
                end
                n_pend = 1'b0;
            end
            ST_WALK: begin
                if (!stall) begin
                    o_cmd.eval  = r_pend;
                    o_cmd.issue = i_sts.can_issue;
                    n_pend      = i_sts.can_issue;
                    if (!r_pend && !i_sts.can_issue) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                n_pend = 1'b0;
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

`ifndef SYNTH
    a_issue_in_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> r_state == ST_WALK)
        else $error("ring read issued outside a query walk");

    a_idle_no_pend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_pend)
        else $error("read still in flight while idle");

    a_finish_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("closing result loaded into a full output register");
`endif

endmodule

// ===== src/wshr_dp.sv =====
// Datapath of the windowed sample history ring: ring memories, pointers, query
// registers, result holding stage and output register. Depends on wshr_pkg.
module wshr_dp import wshr_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int LANES         = LANES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [TIME_W-1:0] i_sample_time,
    input  logic [LEN_W-1:0]  i_sample_len,
    input  logic [DATA_W-1:0] i_lane_a,
    input  logic [DATA_W-1:0] i_lane_b,
    input  logic [DATA_W-1:0] i_lane_c,
    input  logic [DATA_W-1:0] i_lane_d,
    input  logic [SEL_W-1:0]  i_metric_sel,
    input  logic [TIME_W-1:0] i_now_time,
    input  logic [TIME_W-1:0] i_window_len,
    input  logic [CNT_W-1:0]  i_max_out,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_metric_value,
    output logic              o_valid_res,
    output logic              o_last,
    output logic [CNT_W-1:0]  o_copied_so_far
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int LSEL_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(HISTORY_DEPTH);
    localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [LEN_W-1:0]  LANES_L  = LEN_W'(LANES);

    typedef logic [DATA_W-1:0] t_row [LANES];

    // Ring storage
    logic [TIME_W-1:0]       mem_stamp [HISTORY_DEPTH];
    logic [STORED_LEN_W-1:0] mem_len   [HISTORY_DEPTH];
    t_row                    mem_row   [HISTORY_DEPTH];

    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [FILL_W-1:0] r_fill, n_fill;

    // Query registers
    logic [SEL_W-1:0]  r_sel;
    logic              r_sel_ok;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_win;
    logic [CNT_W-1:0]  r_lim;
    logic [FILL_W-1:0] r_idx;
    logic [CNT_W-1:0]  r_copied;

    // Registered read data
    logic [TIME_W-1:0]       r_rd_stamp;
    logic [STORED_LEN_W-1:0] r_rd_len;
    t_row                    r_rd_row;

    // Holding stage: the newest match waits here until it is known whether it is the last.
    logic              r_hold_valid, n_hold_valid;
    logic [DATA_W-1:0] r_hold_value;
    logic [CNT_W-1:0]  r_hold_cnt;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic              r_out_res, n_out_res;
    logic              r_out_last, n_out_last;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    logic [DATA_W-1:0]       in_lanes [MAX_LANES];
    logic [STORED_LEN_W-1:0] rec_len;
    logic                    rec_en;
    logic [SUM_W-1:0]        wr_sum;
    logic [SLOT_W-1:0]       wr_slot;
    logic [SUM_W-1:0]        rd_sum;
    logic [SLOT_W-1:0]       rd_slot;
    t_row                    wr_row;
    logic [TIME_W-1:0]       age;
    logic [DATA_W-1:0]       sel_value;
    logic                    hit;
    logic                    take;
    logic                    out_free;

    assign in_lanes[0] = i_lane_a;
    assign in_lanes[1] = i_lane_b;
    assign in_lanes[2] = i_lane_c;
    assign in_lanes[3] = i_lane_d;

    assign rec_en  = i_cmd.rec && (i_sample_len != '0);
    assign rec_len = (i_sample_len > LANES_L) ? STORED_LEN_W'(LANES)
                                              : i_sample_len[STORED_LEN_W-1:0];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            wr_row[k] = (STORED_LEN_W'(k) < rec_len) ? in_lanes[k] : '0;
        end
    end

    // Slot arithmetic: both operands stay below the depth, so one subtract wraps.
    assign wr_sum  = {1'b0, r_oldest} + SUM_W'(r_fill);
    assign wr_slot = (r_fill < DEPTH_F)
                   ? ((wr_sum >= DEPTH_S) ? SLOT_W'(wr_sum - DEPTH_S) : SLOT_W'(wr_sum))
                   : r_oldest;
    assign rd_sum  = {1'b0, r_oldest} + SUM_W'(r_idx);
    assign rd_slot = (rd_sum >= DEPTH_S) ? SLOT_W'(rd_sum - DEPTH_S) : SLOT_W'(rd_sum);

    always_ff @(posedge i_clk) begin
        if (rec_en) begin
            mem_stamp[wr_slot] <= i_sample_time;
            mem_len[wr_slot]   <= rec_len;
            mem_row[wr_slot]   <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_stamp <= mem_stamp[rd_slot];
            r_rd_len   <= mem_len[rd_slot];
            r_rd_row   <= mem_row[rd_slot];
        end
    end

    always_comb begin
        n_oldest = r_oldest;
        n_fill   = r_fill;
        if (i_cmd.clr) begin
            n_oldest = '0;
            n_fill   = '0;
        end else if (rec_en) begin
            if (r_fill < DEPTH_F) begin
                n_fill = r_fill + 1'b1;
            end else begin
                n_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
            end
        end
    end

    assign age       = r_now - r_rd_stamp;
    assign sel_value = r_rd_row[r_sel[LSEL_W-1:0]];
    assign hit       = r_sel_ok && (r_sel < {1'b0, r_rd_len}) && (age <= r_win)
                    && (r_copied < r_lim);
    assign take      = i_cmd.eval && hit;
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_sts.can_issue  = r_sel_ok && (r_idx < r_fill) && (r_copied < r_lim);
    assign o_sts.hit        = hit;
    assign o_sts.hold_valid = r_hold_valid;
    assign o_sts.out_free   = out_free;

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_value  = r_out_value;
        n_out_res    = r_out_res;
        n_out_last   = r_out_last;
        n_out_cnt    = r_out_cnt;
        if (i_cmd.q_start) begin
            n_hold_valid = 1'b0;
        end else if (take) begin
            n_hold_valid = 1'b1;
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out_value = r_hold_value;
                n_out_res   = 1'b1;
                n_out_last  = 1'b0;
                n_out_cnt   = r_hold_cnt;
            end
        end else if (i_cmd.finish) begin
            n_hold_valid = 1'b0;
            n_out_valid  = 1'b1;
            n_out_last   = 1'b1;
            if (r_hold_valid) begin
                n_out_value = r_hold_value;
                n_out_res   = 1'b1;
                n_out_cnt   = r_hold_cnt;
            end else begin
                n_out_value = '0;
                n_out_res   = 1'b0;
                n_out_cnt   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest     <= '0;
            r_fill       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_oldest     <= n_oldest;
            r_fill       <= n_fill;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_res   <= n_out_res;
        r_out_last  <= n_out_last;
        r_out_cnt   <= n_out_cnt;
        if (i_cmd.q_start) begin
            r_sel    <= i_metric_sel;
            r_sel_ok <= (i_metric_sel < LANES_L);
            r_now    <= i_now_time;
            r_win    <= i_window_len;
            r_lim    <= (i_max_out > MAX_RESULTS) ? MAX_RESULTS : i_max_out;
            r_idx    <= '0;
            r_copied <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (take) begin
                r_copied     <= r_copied + 1'b1;
                r_hold_value <= sel_value;
                r_hold_cnt   <= r_copied + 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_metric_value  = r_out_value;
    assign o_valid_res     = r_out_res;
    assign o_last          = r_out_last;
    assign o_copied_so_far = r_out_cnt;

`ifndef SYNTH
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_F)
        else $error("ring fill count beyond the depth");

    a_take_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_hold_valid |-> out_free)
        else $error("held result displaced while the output register is full");

    a_take_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_copied <= r_lim && r_hold_cnt == r_copied)
        else $error("query copied more values than its limit");
`endif

endmodule
